[src/fcv_pkg.sv]
// ----------------------------------------------------------------------------
// fcv_pkg
// Shared types and constants for the flagella conformation vote core.
// ----------------------------------------------------------------------------
package fcv_pkg;

  localparam int unsigned TimeW  = 24;
  localparam int unsigned WaitW  = 20;
  localparam int unsigned DrawW  = 16;
  localparam int unsigned CountW = 7;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned DrawFracW = 12;

  localparam logic [TimeW-1:0]  TimeMax  = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_TIME       = 3'd0,
    REG_NORMAL_TO_SEMI  = 3'd1,
    REG_CURLY_TO_NORMAL = 3'd2,
    REG_MIN_SEMI        = 3'd3,
    REG_MEAN_SEMI_WAIT  = 3'd4,
    REG_MIN_NORMAL_RUN  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CONF_NORMAL = 2'd0,
    CONF_SEMI   = 2'd1,
    CONF_CURLY  = 2'd2
  } conf_e;

  // Per-motor record held in the state memory.
  typedef struct packed {
    logic             dir_cw;
    logic [TimeW-1:0] interval;
    logic [TimeW-1:0] dwell;
    conf_e            conf;
  } motor_rec_t;

  localparam motor_rec_t RecReset = '{
    dir_cw:   1'b1,
    interval: '0,
    dwell:    '0,
    conf:     CONF_CURLY
  };

  typedef struct packed {
    logic [TimeW-1:0]  step_time;
    logic [TimeW-1:0]  normal_to_semi_time;
    logic [TimeW-1:0]  curly_to_normal_time;
    logic [TimeW-1:0]  min_semi_time;
    logic [WaitW-1:0]  mean_semi_wait;
    logic [CountW-1:0] min_normal_to_run;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0]  motor_index;
    logic             clockwise;
    logic [DrawW-1:0] exp_draw;
    logic             last_motor;
  } in_req_t;

  typedef struct packed {
    logic [IdxW-1:0] out_motor_index;
    logic [1:0]      flagellum_state;
    logic            cell_state_valid;
    logic            cell_state;
    logic            prev_cell_state;
  } out_rsp_t;

endpackage

[src/fcv_motor_mem.sv]
// ----------------------------------------------------------------------------
// fcv_motor_mem
// Per-motor state memory: one write port, one registered read port.
// Entry valid bits make never-written entries read as the reset record.
// ----------------------------------------------------------------------------
module fcv_motor_mem #(
  parameter int unsigned MOTORS = 64,
  parameter int unsigned AddrW  = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output fcv_pkg::motor_rec_t    rdata_o,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  fcv_pkg::motor_rec_t    wdata_i
);

  fcv_pkg::motor_rec_t mem_q [MOTORS];
  logic [MOTORS-1:0]   vld_q;
  fcv_pkg::motor_rec_t rdata_q;
  logic                rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : fcv_pkg::RecReset;

endmodule

[src/fcv_motor_update.sv]
// ----------------------------------------------------------------------------
// fcv_motor_update
// Next-state logic for one motor: interval timer, semi dwell and conformation.
// ----------------------------------------------------------------------------
module fcv_motor_update (
  input  fcv_pkg::motor_rec_t             rec_i,
  input  logic                            cw_i,
  input  logic [fcv_pkg::TimeW-1:0]       dwell_new_i,
  input  fcv_pkg::cfg_t                   cfg_i,
  output fcv_pkg::motor_rec_t             rec_o
);

  localparam int unsigned TW = fcv_pkg::TimeW;

  logic [TW:0]   it_sum;
  logic [TW-1:0] it_acc;
  logic [TW-1:0] it;
  logic [TW-1:0] dwell;
  logic [TW+1:0] curly_limit;
  fcv_pkg::conf_e conf;

  always_comb begin
    it_sum = {1'b0, rec_i.interval} + {1'b0, cfg_i.step_time};
    it_acc = it_sum[TW] ? fcv_pkg::TimeMax : it_sum[TW-1:0];

    // direction change restarts the interval
    if (cw_i && !rec_i.dir_cw) begin
      it    = cfg_i.step_time;
      dwell = dwell_new_i;
    end else if (!cw_i && rec_i.dir_cw) begin
      it    = cfg_i.step_time;
      dwell = '0;
    end else begin
      it    = it_acc;
      dwell = rec_i.dwell;
    end

    curly_limit = {2'b00, cfg_i.normal_to_semi_time} + {2'b00, cfg_i.min_semi_time}
                + {2'b00, dwell};

    conf = rec_i.conf;
    if (cw_i) begin
      if ({2'b00, it} > curly_limit) begin
        conf = fcv_pkg::CONF_CURLY;
      end else if (it > cfg_i.normal_to_semi_time) begin
        conf = fcv_pkg::CONF_SEMI;
      end
    end else if (it > cfg_i.curly_to_normal_time) begin
      conf = fcv_pkg::CONF_NORMAL;
    end

    rec_o.dir_cw   = cw_i;
    rec_o.interval = it;
    rec_o.dwell    = dwell;
    rec_o.conf     = conf;
  end

endmodule

[src/flagella_conformation_vote_core.sv]
// ----------------------------------------------------------------------------
// flagella_conformation_vote_core
// Updates per-motor flagellum conformation and votes run or tumble per step.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | dir | carries
//  --------+----------------------------------+-----+-----------------------------
//  in      | in_valid_i in_ready_o in_req_i   | in  | one motor request per step
//  out     | out_valid_o out_ready_i out_rsp_o| out | conformation, cell decision
//  cfg     | cfg_we_i cfg_idx_i cfg_wdata_i   | in  | register writes, no read-back
//
//  One request per cycle sustained; a stall on out_ready_i freezes the whole
//  pipe. An accepted request passes stage 1 (memory read with dwell multiply),
//  stage 2 (update/vote) and the result register. The rate is set by the
//  single read and write port of the motor memory; a request takes forwarded
//  state from either of the two requests ahead of it on the same motor. Reset
//  clears pipeline, counts and entry valid bits at once; the cell starts tumbling.
// ----------------------------------------------------------------------------
module flagella_conformation_vote_core #(
  parameter int unsigned MOTORS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fcv_pkg::in_req_t                    in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fcv_pkg::out_rsp_t                   out_rsp_o,
  input  logic                                cfg_we_i,
  input  logic [fcv_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [fcv_pkg::CfgDataW-1:0]        cfg_wdata_i
);

  localparam int unsigned AddrW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int unsigned TW    = fcv_pkg::TimeW;
  localparam int unsigned CW    = fcv_pkg::CountW;
  localparam int unsigned ProdW = fcv_pkg::DrawW + fcv_pkg::WaitW;

  // --- configuration registers ---
  fcv_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_time            <= 24'd1000;
      cfg_q.normal_to_semi_time  <= 24'd2000;
      cfg_q.curly_to_normal_time <= 24'd1000;
      cfg_q.min_semi_time        <= 24'd2000;
      cfg_q.mean_semi_wait       <= 20'd1000;
      cfg_q.min_normal_to_run    <= 7'd1;
    end else if (cfg_we_i) begin
      case (fcv_pkg::cfg_reg_e'(cfg_idx_i))
        fcv_pkg::REG_STEP_TIME:       cfg_q.step_time <= cfg_wdata_i;
        fcv_pkg::REG_NORMAL_TO_SEMI:  cfg_q.normal_to_semi_time <= cfg_wdata_i;
        fcv_pkg::REG_CURLY_TO_NORMAL: cfg_q.curly_to_normal_time <= cfg_wdata_i;
        fcv_pkg::REG_MIN_SEMI:        cfg_q.min_semi_time <= cfg_wdata_i;
        fcv_pkg::REG_MEAN_SEMI_WAIT:  cfg_q.mean_semi_wait <= cfg_wdata_i[fcv_pkg::WaitW-1:0];
        fcv_pkg::REG_MIN_NORMAL_RUN:  cfg_q.min_normal_to_run <= cfg_wdata_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // --- pipeline control: everything moves together ---
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  logic in_acc;
  logic in_rng;
  assign in_acc = in_valid_i && adv;
  assign in_rng = {1'b0, in_req_i.motor_index} < (fcv_pkg::IdxW+1)'(MOTORS);

  // --- stage 1: memory read in flight, dwell product computed ---
  logic               s1_valid_q;
  logic               s1_rng_q;
  fcv_pkg::in_req_t   s1_req_q;

  // --- stage 2: record available, update and vote ---
  logic                s2_valid_q;
  logic                s2_rng_q;
  fcv_pkg::in_req_t    s2_req_q;
  fcv_pkg::motor_rec_t s2_rec_q;
  logic [TW-1:0]       s2_dwell_q;
  fcv_pkg::motor_rec_t s2_new;

  // last write, landed at the same edge as stage 1's memory read
  logic                wr_valid_q;
  logic [AddrW-1:0]    wr_addr_q;
  fcv_pkg::motor_rec_t wr_rec_q;

  logic                mem_we;
  fcv_pkg::motor_rec_t mem_rdata;

  assign mem_we = adv && s2_valid_q && s2_rng_q;

  fcv_motor_mem #(
    .MOTORS (MOTORS),
    .AddrW  (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (in_acc && in_rng),
    .raddr_i (in_req_i.motor_index[AddrW-1:0]),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (s2_req_q.motor_index[AddrW-1:0]),
    .wdata_i (s2_new)
  );

  // rounded, saturated semi dwell from the draw
  logic [ProdW-1:0]                 prod;
  logic [ProdW:0]                   prod_rnd;
  logic [ProdW-fcv_pkg::DrawFracW:0] prod_shr;
  logic [TW-1:0]                    dwell_new;

  always_comb begin
    prod     = ProdW'(s1_req_q.exp_draw) * ProdW'(cfg_q.mean_semi_wait);
    prod_rnd = {1'b0, prod} + (ProdW+1)'(1 << (fcv_pkg::DrawFracW - 1));
    prod_shr = prod_rnd[ProdW:fcv_pkg::DrawFracW];
    dwell_new = (|prod_shr[ProdW-fcv_pkg::DrawFracW:TW]) ? fcv_pkg::TimeMax
                                                          : prod_shr[TW-1:0];
  end

  // forwarding: the item ahead writes this cycle, or wrote at the read edge
  logic                fwd_s2;
  logic                fwd_wr;
  fcv_pkg::motor_rec_t s1_rec;

  always_comb begin
    fwd_s2 = s2_valid_q && s2_rng_q
          && (s2_req_q.motor_index[AddrW-1:0] == s1_req_q.motor_index[AddrW-1:0]);
    fwd_wr = wr_valid_q && (wr_addr_q == s1_req_q.motor_index[AddrW-1:0]);
    if (fwd_s2) begin
      s1_rec = s2_new;
    end else if (fwd_wr) begin
      s1_rec = wr_rec_q;
    end else begin
      s1_rec = mem_rdata;
    end
  end

  fcv_motor_update u_update (
    .rec_i       (s2_rec_q),
    .cw_i        (s2_req_q.clockwise),
    .dwell_new_i (s2_dwell_q),
    .cfg_i       (cfg_q),
    .rec_o       (s2_new)
  );

  // --- counts and the run/tumble vote ---
  logic [CW-1:0] normal_cnt_q, normal_cnt_d, normal_nx;
  logic [CW-1:0] semi_cnt_q, semi_cnt_d, semi_nx;
  logic          cell_q, cell_d;
  logic          vote;
  logic          cnt_en;

  always_comb begin
    cnt_en    = s2_valid_q && s2_rng_q;
    normal_nx = normal_cnt_q;
    semi_nx   = semi_cnt_q;
    if (cnt_en && s2_new.conf == fcv_pkg::CONF_NORMAL && normal_cnt_q != fcv_pkg::CountMax) begin
      normal_nx = normal_cnt_q + CW'(1);
    end
    if (cnt_en && s2_new.conf == fcv_pkg::CONF_SEMI && semi_cnt_q != fcv_pkg::CountMax) begin
      semi_nx = semi_cnt_q + CW'(1);
    end
    vote         = !((normal_nx >= cfg_q.min_normal_to_run) && (semi_nx == '0));
    normal_cnt_d = normal_nx;
    semi_cnt_d   = semi_nx;
    cell_d       = cell_q;
    if (s2_valid_q && s2_req_q.last_motor) begin
      normal_cnt_d = '0;
      semi_cnt_d   = '0;
      cell_d       = vote;
    end
  end

  // --- result register ---
  fcv_pkg::out_rsp_t out_rsp_q, out_rsp_d;

  always_comb begin
    out_rsp_d.out_motor_index  = s2_req_q.motor_index;
    out_rsp_d.flagellum_state  = s2_rng_q ? 2'(s2_new.conf) : 2'(fcv_pkg::CONF_NORMAL);
    out_rsp_d.cell_state_valid = s2_req_q.last_motor;
    out_rsp_d.cell_state       = s2_req_q.last_motor && vote;
    out_rsp_d.prev_cell_state  = s2_req_q.last_motor && cell_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      wr_valid_q   <= 1'b0;
      normal_cnt_q <= '0;
      semi_cnt_q   <= '0;
      cell_q       <= 1'b1;
    end else if (adv) begin
      s1_valid_q   <= in_valid_i;
      s2_valid_q   <= s1_valid_q;
      out_valid_q  <= s2_valid_q;
      wr_valid_q   <= mem_we;
      normal_cnt_q <= normal_cnt_d;
      semi_cnt_q   <= semi_cnt_d;
      cell_q       <= cell_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_req_q   <= in_req_i;
      s1_rng_q   <= in_rng;
      s2_req_q   <= s1_req_q;
      s2_rng_q   <= s1_rng_q;
      s2_rec_q   <= s1_rec;
      s2_dwell_q <= dwell_new;
      wr_addr_q  <= s2_req_q.motor_index[AddrW-1:0];
      wr_rec_q   <= s2_new;
      out_rsp_q  <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
